// ===== rtl/core/i2da_pkg.sv =====
// Shared types and constants for the signed integer to decimal ASCII converter.
// Used by the digit cell and the top level; depends on nothing.
package i2da_pkg;

    localparam int DIGIT_BITS = 4;
    localparam logic [6:0] CHAR_ZERO  = 7'd48;
    localparam logic [6:0] CHAR_MINUS = 7'd45;

    typedef struct packed {
        logic clear;
        logic dabble;
        logic move;
    } i2da_cell_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_SKIP,
        ST_EMIT
    } i2da_state_t;

endpackage

// ===== rtl/core/signed_int_to_decimal_ascii_top.sv =====
// Top level of the signed integer to decimal ASCII converter.
// Depends on i2da_pkg and i2da_cell.
//
// Each input word is a two's-complement integer; the block sends its decimal text one
// ASCII character per output word, most significant digit first, with a leading '-' for
// negative values and last_char set on the final character. One number is converted at a
// time. After acceptance the magnitude is shifted bit by bit through a chain of DIGITS BCD
// digit cells, where DIGITS is the digit count of 2^(VALUE_BITS-1); then the sign is sent
// if negative, leading zero digits are dropped (at least one digit is kept), and each
// remaining digit leaves in turn, most significant first.
module signed_int_to_decimal_ascii_top
    import i2da_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [VALUE_BITS-1:0] value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [6:0]                   text_char,
    output logic                         last_char
);

    localparam int DIGITS   = ((VALUE_BITS - 1) * 1233) / 4096 + 1;
    localparam int CNT_BITS = $clog2(VALUE_BITS + 1);
    localparam int REM_BITS = $clog2(DIGITS + 1);

    i2da_state_t           state_reg, state_next;
    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic                  neg_reg, neg_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [REM_BITS-1:0]   rem_reg, rem_next;
    logic                  out_valid_reg, out_valid_next;
    logic [6:0]            char_reg, char_next;
    logic                  last_reg, last_next;

    i2da_cell_ctl_t        cell_ctl;
    logic [VALUE_BITS-1:0] value_u;
    logic                  slot_free;
    logic [DIGIT_BITS-1:0] top_digit;

    logic [DIGITS-1:0]     carry;
    logic [DIGIT_BITS-1:0] digit [DIGITS];

    genvar gi;
    generate
        for (gi = 0; gi < DIGITS; gi++)
        begin : g_cell
            logic                  bit_in;
            logic [DIGIT_BITS-1:0] digit_in;
            if (gi == 0)
            begin : g_first
                assign bit_in   = mag_reg[VALUE_BITS-1];
                assign digit_in = '0;
            end
            else
            begin : g_rest
                assign bit_in   = carry[gi-1];
                assign digit_in = digit[gi-1];
            end
            i2da_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (cell_ctl),
                .bit_in    (bit_in),
                .digit_in  (digit_in),
                .carry_out (carry[gi]),
                .digit_out (digit[gi])
            );
        end
    endgenerate

    assign value_u   = value;
    assign top_digit = digit[DIGITS-1];
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign text_char = char_reg;
    assign last_char = last_reg;

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg && !out_ready;
        char_next      = char_reg;
        last_next      = last_reg;
        cell_ctl       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    neg_next       = value_u[VALUE_BITS-1];
                    mag_next       = value_u[VALUE_BITS-1] ?
                                     (~value_u + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : value_u;
                    cnt_next       = CNT_BITS'(VALUE_BITS);
                    rem_next       = REM_BITS'(DIGITS);
                    cell_ctl.clear = 1'b1;
                    state_next     = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cell_ctl.dabble = 1'b1;
                mag_next        = mag_reg << 1;
                cnt_next        = cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1))
                begin
                    state_next = neg_reg ? ST_SIGN : ST_SKIP;
                end
            end
            ST_SIGN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = CHAR_MINUS;
                    last_next      = 1'b0;
                    state_next     = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (top_digit == '0 && rem_reg != REM_BITS'(1))
                begin
                    cell_ctl.move = 1'b1;
                    rem_next      = rem_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = CHAR_ZERO + {3'b000, top_digit};
                    last_next      = (rem_reg == REM_BITS'(1));
                    cell_ctl.move  = 1'b1;
                    rem_next       = rem_reg - 1'b1;
                    if (rem_reg == REM_BITS'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

endmodule

// ===== rtl/core/i2da_cell.sv =====
// One BCD digit cell of the converter chain: clear, shift-and-add-3 step or digit move.
// Depends on i2da_pkg.
module i2da_cell
    import i2da_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  i2da_cell_ctl_t        ctl,
    input  logic                  bit_in,
    input  logic [DIGIT_BITS-1:0] digit_in,
    output logic                  carry_out,
    output logic [DIGIT_BITS-1:0] digit_out
);

    logic [DIGIT_BITS-1:0] digit_reg;
    logic [DIGIT_BITS-1:0] digit_next;
    logic [DIGIT_BITS-1:0] adj;

    assign adj       = (digit_reg >= 4'd5) ? (digit_reg + 4'd3) : digit_reg;
    assign carry_out = adj[DIGIT_BITS-1];
    assign digit_out = digit_reg;

    always_comb
    begin
        digit_next = digit_reg;
        if (ctl.clear)
        begin
            digit_next = '0;
        end
        else if (ctl.dabble)
        begin
            digit_next = {adj[DIGIT_BITS-2:0], bit_in};
        end
        else if (ctl.move)
        begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

endmodule

// ===== test/tb.sv =====
// Testbench for signed_int_to_decimal_ascii_top: random and directed integers in, ASCII text out.
// A clocked driver and monitor check every character against a built-in predictor.
// Depends on i2da_pkg and the converter RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2da_pkg::*;

    localparam int VALUE_BITS  = 32;
    localparam int IDLE_LIMIT  = 3000;
    localparam int HOLD_START  = 1500;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_WORDS = 89;

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } text_entry_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic signed [VALUE_BITS-1:0] value = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic [6:0]                   text_char;
    logic                         last_char;

    logic [VALUE_BITS-1:0] word_queue[$];
    text_entry_t           expected_text[$];
    text_entry_t           want;
    int                    errors = 0;
    int                    burst_left = 0;
    int                    gap_left = 0;
    int                    rx_cycle = 0;
    int                    hold_left = 0;
    int                    idle_cycles = 0;

    signed_int_to_decimal_ascii_top #(
        .VALUE_BITS(VALUE_BITS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .value(value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .text_char(text_char),
        .last_char(last_char)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic void predict_text(input logic [VALUE_BITS-1:0] word);
        logic [VALUE_BITS-1:0] mag;
        logic [3:0]            digits[$];
        text_entry_t           entry;
        mag = word[VALUE_BITS-1] ? (~word + 1'b1) : word;
        do
        begin
            digits.push_front(4'(mag % 10));
            mag = mag / 10;
        end
        while (mag != 0);
        if (word[VALUE_BITS-1])
        begin
            entry.ch = CHAR_MINUS;
            entry.last = 1'b0;
            expected_text.push_back(entry);
        end
        foreach (digits[k])
        begin
            entry.ch = CHAR_ZERO + 7'(digits[k]);
            entry.last = (k == digits.size() - 1);
            expected_text.push_back(entry);
        end
    endfunction

    function automatic logic [VALUE_BITS-1:0] random_word();
        int          ndigits;
        longint      lo;
        longint      hi;
        longint      mag;
        logic [VALUE_BITS-1:0] word;
        if ($urandom_range(0, 9) < 4)
            return $urandom();
        ndigits = $urandom_range(1, 10);
        lo = 1;
        for (int i = 1; i < ndigits; i++)
            lo = lo * 10;
        hi = lo * 10 - 1;
        if (ndigits == 1)
            lo = 0;
        if (hi > 64'd2147483647)
            hi = 64'd2147483647;
        mag = lo + ($urandom() % (hi - lo + 1));
        word = VALUE_BITS'(mag);
        if ($urandom_range(0, 1) == 1)
            word = ~word + 1'b1;
        return word;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            value <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_text(value);
                void'(word_queue.pop_front());
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 10);
                    gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 60) : 0;
                end
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (word_queue.size() > 0)
                begin
                    in_valid <= 1'b1;
                    value <= word_queue[0];
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            rx_cycle++;
            if (rx_cycle == HOLD_START)
                hold_left = HOLD_CYCLES;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (rx_cycle / 128 % 4)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 1) == 1);
                    2: out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= (rx_cycle % 7 != 3);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_text.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual char %0d last %0b",
                         $time, text_char, last_char);
                errors++;
            end
            else
            begin
                want = expected_text.pop_front();
                if (text_char !== want.ch)
                begin
                    $display("%0t: text_char mismatch, expected %0d, actual %0d",
                             $time, want.ch, text_char);
                    errors++;
                end
                if (last_char !== want.last)
                begin
                    $display("%0t: last_char mismatch, expected %0b, actual %0b",
                             $time, want.last, last_char);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        word_queue.push_back(32'd0);
        word_queue.push_back(32'd1);
        word_queue.push_back(32'hFFFF_FFFF);
        word_queue.push_back(32'd9);
        word_queue.push_back(32'd10);
        word_queue.push_back(-32'sd10);
        word_queue.push_back(32'd99);
        word_queue.push_back(32'd100);
        word_queue.push_back(-32'sd5);
        word_queue.push_back(32'h7FFF_FFFF);
        word_queue.push_back(32'h8000_0000);
        word_queue.push_back(32'h8000_0001);
        word_queue.push_back(32'd999999999);
        word_queue.push_back(32'd1000000000);
        word_queue.push_back(-32'sd999999999);
        word_queue.push_back(-32'sd1000000000);
        word_queue.push_back(32'd1999999999);
        word_queue.push_back(32'd123456789);
        word_queue.push_back(32'h5555_5555);
        word_queue.push_back(32'hAAAA_AAAA);
        word_queue.push_back(32'd1073741824);
        for (int i = 0; i < RANDOM_WORDS; i++)
            word_queue.push_back(random_word());

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (word_queue.size() > 0 || expected_text.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
